@@ design/lowest_free_label_allocator_assert.svh @@
// assertion macros for the lowest free label allocator
// expects clk and rst_n in the scope of the module that uses them
`ifndef LOWEST_FREE_LABEL_ALLOCATOR_ASSERT_SVH
`define LOWEST_FREE_LABEL_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define LFLA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LFLA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LFLA_ASSERT_IMP(lbl, ante, cons, msg)
`define LFLA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/lfla_pkg.sv @@
// shared types and constants for the lowest free label allocator
// no dependencies
package lfla_pkg;

    localparam int DEF_NUM_LABELS = 256;
    localparam int DEF_MAX_BATCH  = 32;
    localparam int COUNT_W        = 6;
    localparam int WANT_W         = COUNT_W + 1;
    localparam int ROW_W          = 32;
    localparam int BIT_W          = 5;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_FLUSH,
        ST_REL
    } state_t;

    typedef struct packed {
        logic accept;
        logic load_work;
        logic grant;
        logic wr_acq;
        logic wr_rel;
        logic next_row;
        logic set_exh;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic is_release;
        logic rel_ok;
        logic found;
        logic final_grant;
        logic last_row;
        logic pend_v;
        logic out_free;
    } stat_t;

endpackage

@@ design/lfla_ctrl.sv @@
// controller state machine for the lowest free label allocator
// depends on lfla_pkg
module lfla_ctrl
    import lfla_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   s_valid,
    input  stat_t  stat,
    output logic   s_ready,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;
    logic   go;

    assign go = !(stat.pend_v && !stat.out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    if (!stat.is_release)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (stat.rel_ok)
                    begin
                        state_next = ST_REL;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (go)
                begin
                    if (stat.found)
                    begin
                        if (stat.final_grant)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else if (stat.last_row)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_LOAD:
            begin
                cmd.load_work = 1'b1;
            end
            ST_SCAN:
            begin
                if (go)
                begin
                    if (stat.found)
                    begin
                        cmd.grant  = 1'b1;
                        cmd.wr_acq = stat.final_grant;
                    end
                    else
                    begin
                        cmd.wr_acq   = 1'b1;
                        cmd.set_exh  = stat.last_row;
                        cmd.next_row = !stat.last_row;
                    end
                end
            end
            ST_FLUSH:
            begin
                cmd.flush = stat.out_free;
            end
            ST_REL:
            begin
                cmd.wr_rel = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ design/lfla_dp.sv @@
// datapath for the lowest free label allocator: usage map, row scan, result register
// depends on lfla_pkg
module lfla_dp
    import lfla_pkg::*;
#(
    parameter int NUM_LABELS = DEF_NUM_LABELS,
    parameter int MAX_BATCH  = DEF_MAX_BATCH,
    localparam int LABEL_W   = $clog2(NUM_LABELS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  op_t                in_op,
    input  logic [COUNT_W-1:0] in_count,
    input  logic [LABEL_W-1:0] in_label,
    input  logic               out_ready,
    output stat_t              stat,
    output logic               out_valid,
    output logic [LABEL_W-1:0] out_label,
    output logic               out_status,
    output logic               out_last
);

    localparam int ROWS   = (NUM_LABELS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = ROW_AW + BIT_W;
    localparam int CNT_W  = $clog2(MAX_BATCH + 1);

    logic [ROW_W-1:0]  mem [ROWS];
    logic [ROWS-1:0]   row_valid_reg;
    logic [ROW_W-1:0]  rd_data_reg;
    logic              rd_valid_reg;
    logic [ROW_W-1:0]  work_reg;
    logic [ROW_AW-1:0] row_reg;
    logic [BIT_W-1:0]  rel_bit_reg;
    logic [CNT_W-1:0]  want_reg;
    logic [CNT_W-1:0]  granted_reg;
    logic              pend_v_reg;
    logic [LABEL_W-1:0] pend_label_reg;
    logic              exh_reg;
    logic              out_valid_reg;
    logic [LABEL_W-1:0] out_label_reg;
    logic              out_status_reg;
    logic              out_last_reg;

    logic [IDX_W-1:0]  in_idx;
    logic [ROW_AW-1:0] in_row;
    logic [WANT_W-1:0] want_ext;
    logic [WANT_W-1:0] want_sat;
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_data;
    logic [ROW_W-1:0]  eff_rd;
    logic [ROW_W-1:0]  res_mask;
    logic [ROW_W-1:0]  avail;
    logic              found;
    logic [BIT_W-1:0]  f_bit;
    logic [ROW_W-1:0]  sel;
    logic [IDX_W-1:0]  f_idx;
    logic              emit_prev;
    logic              emit;

    assign in_idx   = IDX_W'(in_label);
    assign in_row   = in_idx[IDX_W-1:BIT_W];
    assign want_ext = WANT_W'(in_count);

    always_comb
    begin
        if (want_ext == '0)
        begin
            want_sat = WANT_W'(1);
        end
        else if (want_ext > WANT_W'(MAX_BATCH))
        begin
            want_sat = WANT_W'(MAX_BATCH);
        end
        else
        begin
            want_sat = want_ext;
        end
    end

    assign rd_en   = cmd.accept | cmd.next_row;
    assign rd_addr = cmd.accept ? ((in_op == OP_RELEASE) ? in_row : '0)
                                : ROW_AW'(row_reg + 1'b1);
    assign wr_en   = cmd.wr_acq | cmd.wr_rel;
    assign eff_rd  = rd_valid_reg ? rd_data_reg : '0;
    assign wr_data = cmd.wr_rel ? (eff_rd & ~(ROW_W'(1) << rel_bit_reg)) : (work_reg | sel);

    // labels zero and top are never free
    always_comb
    begin
        logic [IDX_W-1:0] idx;
        for (int j = 0; j < ROW_W; j++)
        begin
            idx         = {row_reg, BIT_W'(j)};
            res_mask[j] = (idx == '0) || (idx >= IDX_W'(NUM_LABELS - 1));
        end
    end

    assign avail = ~(work_reg | res_mask);

    always_comb
    begin
        found = 1'b0;
        f_bit = '0;
        for (int j = ROW_W - 1; j >= 0; j--)
        begin
            if (avail[j])
            begin
                found = 1'b1;
                f_bit = BIT_W'(j);
            end
        end
    end

    assign sel   = found ? (ROW_W'(1) << f_bit) : '0;
    assign f_idx = {row_reg, f_bit};

    assign emit_prev = cmd.grant & pend_v_reg;
    assign emit      = emit_prev | cmd.flush;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem[row_reg] <= wr_data;
        end
        if (cmd.load_work)
        begin
            work_reg <= eff_rd;
        end
        else if (cmd.grant)
        begin
            work_reg <= work_reg | sel;
        end
        if (cmd.accept)
        begin
            row_reg     <= (in_op == OP_RELEASE) ? in_row : '0;
            rel_bit_reg <= in_idx[BIT_W-1:0];
            want_reg    <= CNT_W'(want_sat);
            granted_reg <= '0;
        end
        else
        begin
            if (cmd.next_row)
            begin
                row_reg <= ROW_AW'(row_reg + 1'b1);
            end
            if (cmd.grant)
            begin
                granted_reg <= CNT_W'(granted_reg + 1'b1);
            end
        end
        if (cmd.grant)
        begin
            pend_label_reg <= f_idx[LABEL_W-1:0];
        end
        if (emit_prev)
        begin
            out_label_reg  <= pend_label_reg;
            out_status_reg <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.flush)
        begin
            out_label_reg  <= pend_v_reg ? pend_label_reg : '0;
            out_status_reg <= pend_v_reg ? exh_reg : 1'b1;
            out_last_reg   <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            pend_v_reg    <= 1'b0;
            exh_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[row_reg] <= 1'b1;
            end
            if (cmd.accept)
            begin
                pend_v_reg <= 1'b0;
                exh_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.grant)
                begin
                    pend_v_reg <= 1'b1;
                end
                if (cmd.set_exh)
                begin
                    exh_reg <= 1'b1;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_release  = (in_op == OP_RELEASE);
    assign stat.rel_ok      = (in_idx != '0) && (in_idx < IDX_W'(NUM_LABELS - 1));
    assign stat.found       = found;
    assign stat.final_grant = ((CNT_W + 1)'(granted_reg) + 1'b1) == (CNT_W + 1)'(want_reg);
    assign stat.last_row    = (row_reg == ROW_AW'(ROWS - 1));
    assign stat.pend_v      = pend_v_reg;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_label  = out_label_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

@@ design/lowest_free_label_allocator.sv @@
// Lowest free label allocator. Labels 1 to NUM_LABELS-2 are tracked in a usage map held as
// 32-label rows in a single-port-read memory; the map is all free after reset. An acquire word
// grants up to count labels (0 taken as 1, capped at MAX_BATCH) in ascending order, one result
// word per grant, tlast on the final one; tuser carries the exhausted status, and a request
// finding nothing free returns label 0 with status set. A release word frees one label and
// returns nothing. One word is worked on at a time: a release reads its row and then writes it
// back; an acquire loads one map row at a time, scanning from label 1 upward, grants from the
// loaded row and then finishes. Output waits in a register, so a new
// word may be accepted while the last result is still pending.
// depends on lfla_pkg, lfla_ctrl, lfla_dp and lowest_free_label_allocator_assert.svh
`include "lowest_free_label_allocator_assert.svh"

module lowest_free_label_allocator
    import lfla_pkg::*;
#(
    parameter int NUM_LABELS  = DEF_NUM_LABELS,
    parameter int MAX_BATCH   = DEF_MAX_BATCH,
    localparam int LABEL_W    = $clog2(NUM_LABELS),
    localparam int IN_DATA_W  = ((COUNT_W + LABEL_W + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((LABEL_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // count, label
    input  logic                  s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // granted_label
    output logic                  m_tuser,   // status
    output logic                  m_tlast
);

    cmd_t               cmd;
    stat_t              stat;
    logic [LABEL_W-1:0] out_label;

    lfla_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .stat    (stat),
        .s_ready (s_tready),
        .cmd     (cmd)
    );

    lfla_dp #(
        .NUM_LABELS (NUM_LABELS),
        .MAX_BATCH  (MAX_BATCH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_op      (op_t'(s_tuser)),
        .in_count   (s_tdata[COUNT_W-1:0]),
        .in_label   (s_tdata[COUNT_W+LABEL_W-1:COUNT_W]),
        .out_ready  (m_tready),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_label  (out_label),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = OUT_DATA_W'(out_label);

    `LFLA_ASSERT_IMP(a_grant_needs_free, cmd.grant, stat.found, "grant without a free label")
    `LFLA_ASSERT_IMP(a_ok_label_nonzero, m_tvalid && !m_tuser, out_label != '0,
        "ok result carries label zero")
    `LFLA_ASSERT_IMP(a_zero_label_final, m_tvalid && (out_label == '0), m_tuser && m_tlast,
        "empty grant not marked exhausted and last")
    `LFLA_ASSERT_NXT(a_flush_shows, cmd.flush, m_tvalid && m_tlast,
        "finishing a request did not present a last word")

endmodule

@@ test/tb_lowest_free_label_allocator.sv @@
// self-checking testbench for lowest_free_label_allocator: acquire and release words in,
// granted labels checked against a label map kept in the scoreboard class
// depends on lfla_pkg and the allocator rtl
module tb_lowest_free_label_allocator;
    import lfla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LABEL_TOP   = DEF_NUM_LABELS - 1;
    localparam int MAX_GRANT   = DEF_MAX_BATCH;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 100;
    localparam int WORD_TARGET = 130;

    typedef struct {
        logic [7:0] label;
        logic       status;
        logic       last;
    } grant_t;

    class label_map_model;
        bit [DEF_NUM_LABELS-1:0] used_labels;
        grant_t expected_grants[$];
        int errors;
        int grants_checked;
        int exhausted_seen;
        int partial_seen;
        int acquires;
        int releases;

        // returns 1 when the word had any effect on the map or gave results
        function bit note_word(op_t op, bit [5:0] count, bit [7:0] label);
            int want;
            bit [7:0] picks[$];
            grant_t g;
            if (op == OP_RELEASE)
            begin
                releases++;
                if (label == 0 || label >= LABEL_TOP || !used_labels[label])
                    return 1'b0;
                used_labels[label] = 1'b0;
                return 1'b1;
            end
            acquires++;
            want = (count == 0) ? 1 : (count > MAX_GRANT) ? MAX_GRANT : int'(count);
            for (int i = 1; i < LABEL_TOP && picks.size() < want; i++)
            begin
                if (!used_labels[i])
                begin
                    used_labels[i] = 1'b1;
                    picks.push_back(i[7:0]);
                end
            end
            if (picks.size() == 0)
            begin
                g.label  = 8'd0;
                g.status = 1'b1;
                g.last   = 1'b1;
                expected_grants.push_back(g);
                return 1'b1;
            end
            foreach (picks[k])
            begin
                g.label  = picks[k];
                g.last   = (k == picks.size() - 1);
                g.status = g.last && (picks.size() < want);
                expected_grants.push_back(g);
            end
            return 1'b1;
        endfunction

        function void check_grant(logic [7:0] label, logic status, logic last);
            grant_t e;
            if (expected_grants.size() == 0)
            begin
                $error("unexpected result word: granted_label %0d status %0d last %0d",
                       label, status, last);
                errors++;
                return;
            end
            e = expected_grants.pop_front();
            grants_checked++;
            if (status && last)
            begin
                if (label == 0)
                    exhausted_seen++;
                else
                    partial_seen++;
            end
            if (label !== e.label)
            begin
                $error("granted_label mismatch: expected %0d, actual %0d", e.label, label);
                errors++;
            end
            if (status !== e.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", e.status, status);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last mismatch: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;  // count, label
    logic        s_tuser = 1'b0;  // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;  // granted_label
    logic        m_tuser;  // status
    logic        m_tlast;

    label_map_model label_map = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int effective_words;
    int cycle_count;

    lowest_free_label_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // result side: check on handshake, then pick next tready
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                label_map.check_grant(m_tdata, m_tuser, m_tlast);
            if (hold_request > 0 && !hold_done)
            begin
                hold_left = hold_request;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_word(op_t op, bit [5:0] count, bit [7:0] label);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            s_tuser  <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, label, count};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (label_map.note_word(op, count, label))
            effective_words++;
    endtask

    task automatic random_word();
        op_t op;
        bit [5:0] count;
        bit [7:0] label;
        int pick;
        op = ($urandom_range(0, 99) < 65) ? OP_RELEASE : OP_ACQUIRE;
        label = ($urandom_range(0, 99) < 6) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(1, 254));
        pick = $urandom_range(0, 99);
        if (op == OP_RELEASE || pick >= 90)
            count = 6'($urandom_range(33, 63));
        else if (pick < 60)
            count = 6'($urandom_range(1, 5));
        else if (pick < 72)
            count = 6'd0;
        else
            count = 6'($urandom_range(6, 32));
        if (op == OP_RELEASE && $urandom_range(0, 1))
            count = 6'($urandom_range(0, 32));
        send_word(op, count, label);
    endtask

    task automatic directed_words();
        send_word(OP_ACQUIRE, 6'd0, 8'hFF);
        send_word(OP_ACQUIRE, 6'd32, 8'h00);
        send_word(OP_ACQUIRE, 6'd63, 8'hA5);
        send_word(OP_RELEASE, 6'd63, 8'd0);
        send_word(OP_RELEASE, 6'd0, 8'd255);
        send_word(OP_RELEASE, 6'd17, 8'd200);
        send_word(OP_RELEASE, 6'd0, 8'd5);
        send_word(OP_RELEASE, 6'd40, 8'd20);
        send_word(OP_ACQUIRE, 6'd3, 8'd77);
        // fill the map, the last of these runs dry part way
        repeat (6)
            send_word(OP_ACQUIRE, 6'd32, 8'($urandom_range(0, 255)));
        send_word(OP_ACQUIRE, 6'd1, 8'd0);
        send_word(OP_RELEASE, 6'd0, 8'd254);
        send_word(OP_RELEASE, 6'd0, 8'd1);
        send_word(OP_ACQUIRE, 6'd2, 8'd3);
        send_word(OP_ACQUIRE, 6'd40, 8'd3);
    endtask

    initial
    begin
        send_idle_pct   = 12;
        recv_idle_pct   = 82;
        hold_request    = 0;
        effective_words = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();
        while (effective_words < WORD_TARGET / 3)
            random_word();

        send_idle_pct = 82;
        recv_idle_pct = 12;
        while (effective_words < 2 * WORD_TARGET / 3)
            random_word();

        // long receiver stall with the sender pushing, input must back up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 400;
        repeat (12)
            send_word(OP_ACQUIRE, 6'($urandom_range(1, 4)), 8'($urandom_range(0, 255)));
        while (effective_words < WORD_TARGET)
            random_word();

        s_tvalid <= 1'b0;
        while (label_map.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        $display("run covered %0d acquire and %0d release words, %0d result words checked",
                 label_map.acquires, label_map.releases, label_map.grants_checked);
        $display("nothing-free results %0d, partial grants %0d, mismatches %0d",
                 label_map.exhausted_seen, label_map.partial_seen, label_map.errors);
        if (label_map.errors == 0 && label_map.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
